/* src/nscf_pkg.sv */
// Shared types and constants for the NMEA sentence checksum framer.
package nscf_pkg;

  // Result status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_MISMATCH = 3'd1;
  localparam logic [2:0] ST_BAD_HEX  = 3'd2;
  localparam logic [2:0] ST_NO_STAR  = 3'd3;
  localparam logic [2:0] ST_TOO_LONG = 3'd4;

  // Sentence body limit in bytes, counted from the key start
  localparam int unsigned LINE_MAX = 128;

  // One framed sentence result
  typedef struct packed {
    logic [2:0] status;
    logic [7:0] sentence_length;
    logic [7:0] calc_checksum;
    logic [7:0] read_checksum;
  } res_t;

endpackage

/* src/nscf_parser.sv */
// Sentence parser: key hunt, checksum accumulation, hex read and line end detection.
module nscf_parser
  import nscf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  logic [7:0] rx_byte,
  input  logic [2:0] wanted_type,
  input  logic       combined_talker,
  output logic       res_en,
  output res_t       res
);

  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_BODY = 3'd1,
    PH_DIG1 = 3'd2,
    PH_DIG2 = 3'd3,
    PH_TAIL = 3'd4
  } phase_t;

  typedef struct packed {
    phase_t     ph;
    logic [7:0] x;
    logic [7:0] h;
    logic [7:0] cnt;
    logic [2:0] err;
  } ctx_t;

  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_STAR = 8'h2A;
  localparam logic [7:0] CNT_LIM = 8'(LINE_MAX - 1);
  localparam logic [7:0] CNT_MAX = 8'hFF;
  localparam logic [7:0] KEY_LEN = 8'd5;

  // Key text for the selected sentence; top bit flags a usable selector
  function automatic logic [40:0] key_lookup(logic [2:0] sel, logic gn);
    logic [40:0] k;
    k = '0;
    unique case (sel)
      3'd0:    k = {1'b1, gn ? 40'("GNRMC") : 40'("GPRMC")};
      3'd1:    k = {1'b1, 40'("GPVTG")};
      3'd2:    k = {1'b1, gn ? 40'("GNGGA") : 40'("GPGGA")};
      3'd3:    k = {1'b1, 40'("GPGSA")};
      3'd4:    k = {1'b1, 40'("GPGSV")};
      3'd5:    k = {1'b1, 40'("GPGLL")};
      default: k = '0;
    endcase
    return k;
  endfunction

  // Uppercase hex digit decode; top bit flags a valid digit
  function automatic logic [4:0] hex_decode(logic [7:0] b);
    logic [4:0] d;
    d = '0;
    if (b >= 8'h30 && b <= 8'h39) begin
      d = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      d = {1'b1, 4'(b - 8'h37)};
    end
    return d;
  endfunction

  // Advance the sentence context by one body byte
  function automatic ctx_t take(ctx_t s, logic [7:0] b);
    ctx_t       n;
    logic       beyond;
    logic [4:0] hd;
    n      = s;
    beyond = (s.cnt >= CNT_LIM);
    hd     = hex_decode(b);
    unique case (s.ph)
      PH_BODY: begin
        if (beyond) begin
          n.err = ST_TOO_LONG;
          n.ph  = PH_TAIL;
        end else if (b == CH_STAR) begin
          n.ph = PH_DIG1;
        end else begin
          n.x = s.x ^ b;
        end
      end
      PH_DIG1, PH_DIG2: begin
        if (beyond) begin
          n.err = ST_TOO_LONG;
          n.ph  = PH_TAIL;
        end else if (!hd[4]) begin
          n.err = ST_BAD_HEX;
          n.ph  = PH_TAIL;
        end else if (s.ph == PH_DIG1) begin
          n.h  = {hd[3:0], 4'h0};
          n.ph = PH_DIG2;
        end else begin
          n.h  = {s.h[7:4], hd[3:0]};
          n.ph = PH_TAIL;
        end
      end
      default: begin
      end
    endcase
    if (s.cnt != CNT_MAX) begin
      n.cnt = s.cnt + 8'd1;
    end
    return n;
  endfunction

  logic [39:0] key_window, key_window_next;
  ctx_t        ctx, ctx_next;
  logic        last_was_cr, last_was_cr_next;

  logic [40:0] key_sel;
  logic [39:0] win_shift;
  ctx_t        ctx_cr;
  logic [2:0]  st;

  assign key_sel   = key_lookup(wanted_type, combined_talker);
  assign win_shift = {key_window[31:0], rx_byte};

  // Status of the sentence that ends at this line feed
  always_comb begin
    if (ctx.err != ST_OK) begin
      st = ctx.err;
    end else if (ctx.ph == PH_BODY) begin
      st = ST_NO_STAR;
    end else if (ctx.ph == PH_DIG1 || ctx.ph == PH_DIG2) begin
      st = ST_BAD_HEX;
    end else begin
      st = (ctx.h == ctx.x) ? ST_OK : ST_MISMATCH;
    end
  end

  assign res.status          = st;
  assign res.sentence_length = ctx.cnt;
  assign res.calc_checksum   = ctx.x;
  assign res.read_checksum   = (st == ST_OK || st == ST_MISMATCH) ? ctx.h : 8'h00;

  // Fold a pending CR into the body when no LF follows it
  assign ctx_cr = last_was_cr ? take(ctx, CH_CR) : ctx;

  // Next state for one byte
  always_comb begin
    key_window_next  = key_window;
    ctx_next         = ctx;
    last_was_cr_next = last_was_cr;
    res_en           = 1'b0;
    if (en) begin
      if (ctx.ph == PH_HUNT) begin
        key_window_next = win_shift;
        if (key_sel[40] && win_shift == key_sel[39:0]) begin
          ctx_next.ph  = PH_BODY;
          ctx_next.x   = win_shift[39:32] ^ win_shift[31:24] ^ win_shift[23:16]
                       ^ win_shift[15:8] ^ win_shift[7:0];
          ctx_next.h   = 8'h00;
          ctx_next.cnt = KEY_LEN;
          ctx_next.err = ST_OK;
          last_was_cr_next = 1'b0;
        end
      end else if (last_was_cr && rx_byte == CH_LF) begin
        res_en           = 1'b1;
        key_window_next  = '0;
        ctx_next         = '{ph: PH_HUNT, x: 8'h00, h: 8'h00, cnt: 8'h00, err: ST_OK};
        last_was_cr_next = 1'b0;
      end else if (rx_byte == CH_CR) begin
        ctx_next         = ctx_cr;
        last_was_cr_next = 1'b1;
      end else begin
        ctx_next         = take(ctx_cr, rx_byte);
        last_was_cr_next = 1'b0;
      end
    end
  end

  // Hold sentence state
  always_ff @(posedge clk) begin
    if (rst) begin
      key_window  <= '0;
      ctx         <= '{ph: PH_HUNT, x: 8'h00, h: 8'h00, cnt: 8'h00, err: ST_OK};
      last_was_cr <= 1'b0;
    end else begin
      key_window  <= key_window_next;
      ctx         <= ctx_next;
      last_was_cr <= last_was_cr_next;
    end
  end

`ifndef SYNTH
  a_hunt_clean: assert property (@(posedge clk) disable iff (rst)
    (ctx.ph == PH_HUNT) |-> (ctx.cnt == 8'h00 && !last_was_cr && ctx.err == ST_OK))
    else $error("hunt phase with leftover sentence state");
  a_body_count: assert property (@(posedge clk) disable iff (rst)
    (ctx.ph != PH_HUNT) |-> (ctx.cnt >= KEY_LEN))
    else $error("sentence count below key length");
  a_emit_rehunt: assert property (@(posedge clk) disable iff (rst)
    res_en |=> (ctx.ph == PH_HUNT))
    else $error("parser did not return to hunting after a result");
`endif

endmodule

/* src/nscf_result_q.sv */
// Two-entry result queue: two slots with read and write pointers.
module nscf_result_q
  import nscf_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  res_t push_data,
  output logic room,
  output logic res_valid,
  input  logic res_ready,
  output res_t head
);

  res_t       slots [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign pop       = res_valid && res_ready;
  assign res_valid = (count != 2'd0);
  assign room      = (count != 2'd2);
  assign head      = slots[rd_ptr];

  // Store results
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && count == 2'd2))
    else $error("result pushed into a full queue");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("result queue occupancy out of range");
  a_ptr_match: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd0 || count == 2'd2) |-> (wr_ptr == rd_ptr))
    else $error("queue pointers disagree with occupancy");
`endif

endmodule

/* src/nmea_sentence_checksum_framer.sv */
// Top level of the NMEA sentence checksum framer.
// Takes one received character per transfer on the rx channel, one every clock
// cycle, and gives one result per sentence on the res channel when the LF of a
// CR LF pair arrives after the configured key. A byte is held in the input
// register and parsed by combinational logic into a two-entry result queue,
// so a result is offered on the res channel once its LF has left the input
// register and the result is written into the queue. The rx side stalls
// only while two results wait untaken in the queue. Registers:
// index 0 wanted_type (reset 0), index 1 combined_talker (reset 1); write them
// only while the block is idle.
module nmea_sentence_checksum_framer
  import nscf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [2:0] cfg_data,
  input  logic       rx_valid,
  output logic       rx_ready,
  input  logic [7:0] rx_byte,
  output logic       res_valid,
  input  logic       res_ready,
  output logic [2:0] status,
  output logic [7:0] sentence_length,
  output logic [7:0] calc_checksum,
  output logic [7:0] read_checksum
);

  localparam logic REG_WANTED_TYPE = 1'b0;
  localparam logic REG_COMBINED    = 1'b1;

  logic [2:0] wanted_type;
  logic       combined_talker;
  logic [7:0] rx_q;
  logic       rx_full;
  logic       room;
  logic       proc_en;
  logic       res_en;
  res_t       res_new, head;

  assign proc_en  = rx_full && room;
  assign rx_ready = !rx_full || proc_en;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      wanted_type     <= 3'd0;
      combined_talker <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WANTED_TYPE: wanted_type     <= cfg_data;
        REG_COMBINED:    combined_talker <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Input register: load on transfer, drop once parsed
  always_ff @(posedge clk) begin
    if (rx_valid && rx_ready) begin
      rx_q <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_full <= 1'b0;
    end else if (rx_valid && rx_ready) begin
      rx_full <= 1'b1;
    end else if (proc_en) begin
      rx_full <= 1'b0;
    end
  end

  nscf_parser u_parser (
    .clk             (clk),
    .rst             (rst),
    .en              (proc_en),
    .rx_byte         (rx_q),
    .wanted_type     (wanted_type),
    .combined_talker (combined_talker),
    .res_en          (res_en),
    .res             (res_new)
  );

  nscf_result_q u_result_q (
    .clk       (clk),
    .rst       (rst),
    .push      (res_en),
    .push_data (res_new),
    .room      (room),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .head      (head)
  );

  assign status          = head.status;
  assign sentence_length = head.sentence_length;
  assign calc_checksum   = head.calc_checksum;
  assign read_checksum   = head.read_checksum;

`ifndef SYNTH
  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    (rx_full && !rx_ready) |-> !room)
    else $error("input stalled while result queue has room");
  a_push_gated: assert property (@(posedge clk) disable iff (rst)
    res_en |-> proc_en)
    else $error("result produced without a parsed byte");
  a_held_byte: assert property (@(posedge clk) disable iff (rst)
    (rx_full && !proc_en) |=> ($stable(rx_q) && rx_full))
    else $error("unparsed input byte lost");
`endif

endmodule
